// ===== rtl/pps_pkg.sv =====
package pps_pkg;

  localparam int unsigned MaxTasksDef     = 16;
  localparam int unsigned PriorityBitsDef = 8;
  localparam int unsigned TimeW           = 16;
  localparam int unsigned SlotW           = 4;
  localparam int unsigned PrioInW         = 8;

  typedef enum logic {
    KIND_LOAD = 1'b0,
    KIND_TICK = 1'b1
  } kind_e;

  typedef enum logic [1:0] {
    ST_LOADED = 2'd0,
    ST_FULL   = 2'd1,
    ST_RAN    = 2'd2,
    ST_IDLE   = 2'd3
  } status_e;

  typedef struct packed {
    kind_e               kind;
    logic [TimeW-1:0]    arrival_time;
    logic [TimeW-1:0]    burst_length;
    logic [PrioInW-1:0]  task_priority;
  } req_t;

  typedef struct packed {
    status_e             status;
    logic [SlotW-1:0]    slot;
    logic                finished;
    logic [TimeW-1:0]    completion_time;
    logic [TimeW-1:0]    turnaround;
    logic [TimeW-1:0]    waiting;
    logic [TimeW-1:0]    response;
    logic                all_done;
    logic [TimeW-1:0]    time_now;
  } rsp_t;

endpackage

// ===== rtl/preemptive_priority_scheduler_unit.sv =====
// Preemptive priority scheduler. A request is taken when start_i is high and busy_o is low.
// A load request writes the task into the next free table slot, or reports ST_FULL if none is
// free, and answers in the next cycle; busy_o stays low, so loads can follow each other in every
// cycle. A tick request scans the task table, one slot per cycle through the single read port of
// the table memory; busy_o stays high through S_SCAN, S_LAST and S_WB, and the result appears as
// busy_o falls. With no task loaded the tick answers like a load. Every result is on result_o
// for exactly one cycle, marked by valid_o, and cannot be held off: the receiver must take it
// in that cycle. The table needs no clearing after reset, only loaded slots are ever scanned.
module preemptive_priority_scheduler_unit #(
  parameter int unsigned MAX_TASKS     = pps_pkg::MaxTasksDef,
  parameter int unsigned PRIORITY_BITS = pps_pkg::PriorityBitsDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  output logic          busy_o,
  input  pps_pkg::req_t req_i,
  output logic          valid_o,
  output pps_pkg::rsp_t result_o
);

  localparam int unsigned IdxW = $clog2(MAX_TASKS);
  localparam int unsigned CntW = $clog2(MAX_TASKS + 1);
  localparam int unsigned TW   = pps_pkg::TimeW;

  typedef struct packed {
    logic [TW-1:0]            arrival;
    logic [TW-1:0]            burst;
    logic [TW-1:0]            remaining;
    logic [PRIORITY_BITS-1:0] prio;
    logic [TW-1:0]            first_run;
  } entry_t;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_SCAN = 4'b0010,
    S_LAST = 4'b0100,
    S_WB   = 4'b1000
  } state_e;

  entry_t mem_q [MAX_TASKS];
  entry_t rdata_q;
  logic [IdxW-1:0] rd_addr;
  logic            mem_we;
  logic [IdxW-1:0] mem_waddr;
  entry_t          mem_wdata;

  state_e          state_q, state_d;
  logic [CntW-1:0] task_cnt_q, task_cnt_d;
  logic [CntW-1:0] done_cnt_q, done_cnt_d;
  logic [TW-1:0]   time_q, time_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic            chk_q, chk_d;
  logic [IdxW-1:0] chk_idx_q;
  logic            found_q, found_d;
  entry_t          best_q, best_d;
  logic [IdxW-1:0] best_idx_q, best_idx_d;
  logic            valid_q, valid_d;
  pps_pkg::rsp_t   rsp_q, rsp_d;

  logic            accept;
  logic            elig;
  logic            last_idx;
  logic [TW-1:0]   time_inc;
  logic [TW-1:0]   rem_new;
  logic [TW-1:0]   fr_new;
  logic [TW-1:0]   tat;
  logic [TW-1:0]   load_burst;
  entry_t          load_entry;
  entry_t          wb_entry;

  assign accept   = start_i && (state_q == S_IDLE);
  assign busy_o   = (state_q != S_IDLE);
  assign valid_o  = valid_q;
  assign result_o = rsp_q;
  assign rd_addr  = idx_q;

  // table memory
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    rdata_q <= mem_q[rd_addr];
  end

  always_comb begin
    time_inc   = (time_q == '1) ? time_q : time_q + TW'(1);
    rem_new    = best_q.remaining - TW'(1);
    fr_new     = (best_q.remaining == best_q.burst) ? time_q : best_q.first_run;
    tat        = time_inc - best_q.arrival;
    load_burst = (req_i.burst_length == '0) ? TW'(1) : req_i.burst_length;
    last_idx   = ((CntW'(idx_q) + CntW'(1)) == task_cnt_q);
    elig       = chk_q && (rdata_q.arrival <= time_q) && (rdata_q.remaining != '0) &&
                 (!found_q || (rdata_q.prio > best_q.prio));

    load_entry.arrival   = req_i.arrival_time;
    load_entry.burst     = load_burst;
    load_entry.remaining = load_burst;
    load_entry.prio      = PRIORITY_BITS'(req_i.task_priority);
    load_entry.first_run = '0;

    wb_entry           = best_q;
    wb_entry.remaining = rem_new;
    wb_entry.first_run = fr_new;
  end

  always_comb begin
    state_d    = state_q;
    task_cnt_d = task_cnt_q;
    done_cnt_d = done_cnt_q;
    time_d     = time_q;
    idx_d      = idx_q;
    chk_d      = (state_q == S_SCAN);
    found_d    = found_q;
    best_d     = best_q;
    best_idx_d = best_idx_q;
    valid_d    = 1'b0;
    rsp_d      = rsp_q;
    mem_we     = 1'b0;
    mem_waddr  = task_cnt_q[IdxW-1:0];
    mem_wdata  = load_entry;

    if (elig) begin
      found_d    = 1'b1;
      best_d     = rdata_q;
      best_idx_d = chk_idx_q;
    end

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          rsp_d                 = '0;
          rsp_d.time_now        = time_q;
          rsp_d.all_done        = (done_cnt_q == task_cnt_q);
          if (req_i.kind == pps_pkg::KIND_LOAD) begin
            valid_d = 1'b1;
            if (task_cnt_q == CntW'(MAX_TASKS)) begin
              rsp_d.status = pps_pkg::ST_FULL;
            end else begin
              mem_we         = 1'b1;
              task_cnt_d     = task_cnt_q + CntW'(1);
              rsp_d.status   = pps_pkg::ST_LOADED;
              rsp_d.slot     = pps_pkg::SlotW'(task_cnt_q[IdxW-1:0]);
              rsp_d.all_done = 1'b0;
            end
          end else if (task_cnt_q == '0) begin
            valid_d        = 1'b1;
            time_d         = time_inc;
            rsp_d.status   = pps_pkg::ST_IDLE;
            rsp_d.time_now = time_inc;
          end else begin
            idx_d   = '0;
            found_d = 1'b0;
            state_d = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (last_idx) begin
          state_d = S_LAST;
        end else begin
          idx_d = idx_q + IdxW'(1);
        end
      end
      S_LAST: begin
        state_d = S_WB;
      end
      S_WB: begin
        valid_d        = 1'b1;
        state_d        = S_IDLE;
        time_d         = time_inc;
        rsp_d          = '0;
        rsp_d.time_now = time_inc;
        rsp_d.all_done = (done_cnt_q == task_cnt_q);
        if (!found_q) begin
          rsp_d.status = pps_pkg::ST_IDLE;
        end else begin
          mem_we       = 1'b1;
          mem_waddr    = best_idx_q;
          mem_wdata    = wb_entry;
          rsp_d.status = pps_pkg::ST_RAN;
          rsp_d.slot   = pps_pkg::SlotW'(best_idx_q);
          if (rem_new == '0) begin
            done_cnt_d            = done_cnt_q + CntW'(1);
            rsp_d.finished        = 1'b1;
            rsp_d.completion_time = time_inc;
            rsp_d.turnaround      = tat;
            rsp_d.waiting         = (tat >= best_q.burst) ? tat - best_q.burst : '0;
            rsp_d.response        = fr_new - best_q.arrival;
            rsp_d.all_done        = ((done_cnt_q + CntW'(1)) == task_cnt_q);
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      task_cnt_q <= '0;
      done_cnt_q <= '0;
      time_q     <= '0;
      idx_q      <= '0;
      chk_q      <= 1'b0;
      found_q    <= 1'b0;
      valid_q    <= 1'b0;
    end else begin
      state_q    <= state_d;
      task_cnt_q <= task_cnt_d;
      done_cnt_q <= done_cnt_d;
      time_q     <= time_d;
      idx_q      <= idx_d;
      chk_q      <= chk_d;
      found_q    <= found_d;
      valid_q    <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    chk_idx_q  <= idx_q;
    best_q     <= best_d;
    best_idx_q <= best_idx_d;
    rsp_q      <= rsp_d;
  end

  a_done_le_tasks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_cnt_q <= task_cnt_q)
    else $error("more tasks completed than loaded");

  a_scan_in_table: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> (CntW'(idx_q) < task_cnt_q))
    else $error("scan beyond loaded slots");

  a_wb_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WB) |=> (valid_o && (result_o.status == pps_pkg::ST_RAN ||
                                       result_o.status == pps_pkg::ST_IDLE)))
    else $error("tick finished without a result");

  a_time_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |=> (time_q == $past(time_q)) || (state_q == S_IDLE))
    else $error("time moved during scan");

  a_finished_ran: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && result_o.finished) |-> (result_o.status == pps_pkg::ST_RAN))
    else $error("completion reported without a run");

endmodule

// ===== test/preemptive_priority_scheduler_unit_test.sv =====
`timescale 1ns / 1ps
module preemptive_priority_scheduler_unit_test;

  localparam int unsigned TimeW = pps_pkg::TimeW;
  localparam int unsigned SlotW = pps_pkg::SlotW;
  localparam int unsigned PrioInW = pps_pkg::PrioInW;
  localparam int unsigned NumSlots = pps_pkg::MaxTasksDef;
  localparam int unsigned IdleLimit = 2000;
  localparam int unsigned WalkTaskCap = 11;
  localparam logic [PrioInW-1:0] PrioMask = PrioInW'((1 << pps_pkg::PriorityBitsDef) - 1);
  localparam logic [TimeW-1:0] TimeTop = {TimeW{1'b1}};

  class schedule_tracker;
    logic [TimeW-1:0] arrival [NumSlots];
    logic [TimeW-1:0] burst [NumSlots];
    logic [TimeW-1:0] remaining [NumSlots];
    logic [PrioInW-1:0] prio [NumSlots];
    logic [TimeW-1:0] first_run [NumSlots];
    int unsigned task_count;
    int unsigned done_count;
    logic [TimeW-1:0] now;
    pps_pkg::rsp_t sched_rsp_q[$];
    int unsigned n_load, n_tick, n_full, n_idle, n_finished, n_errors;

    function new();
      now = '0;
    endfunction

    function pps_pkg::rsp_t predict_rsp(pps_pkg::req_t r);
      pps_pkg::rsp_t o;
      int best;
      logic [TimeW-1:0] bur;
      o = '0;
      best = -1;
      if (r.kind == pps_pkg::KIND_LOAD) begin
        n_load++;
        if (task_count < NumSlots) begin
          bur = (r.burst_length == '0) ? TimeW'(1) : r.burst_length;
          arrival[task_count] = r.arrival_time;
          burst[task_count] = bur;
          remaining[task_count] = bur;
          prio[task_count] = r.task_priority & PrioMask;
          first_run[task_count] = '0;
          o.status = pps_pkg::ST_LOADED;
          o.slot = SlotW'(task_count);
          task_count++;
        end else begin
          o.status = pps_pkg::ST_FULL;
          n_full++;
        end
      end else begin
        n_tick++;
        for (int i = 0; i < int'(task_count); i++) begin
          if (arrival[i] <= now && remaining[i] != '0 && (best < 0 || prio[i] > prio[best])) begin
            best = i;
          end
        end
        if (best >= 0 && remaining[best] == burst[best]) begin
          first_run[best] = now;
        end
        if (now != TimeTop) begin
          now = now + 1'b1;
        end
        if (best < 0) begin
          o.status = pps_pkg::ST_IDLE;
          n_idle++;
        end else begin
          remaining[best] = remaining[best] - 1'b1;
          o.status = pps_pkg::ST_RAN;
          o.slot = SlotW'(best);
          if (remaining[best] == '0) begin
            o.finished = 1'b1;
            o.completion_time = now;
            o.turnaround = now - arrival[best];
            o.waiting = (o.turnaround >= burst[best]) ? o.turnaround - burst[best] : '0;
            o.response = first_run[best] - arrival[best];
            done_count++;
            n_finished++;
          end
        end
      end
      o.all_done = (done_count == task_count);
      o.time_now = now;
      return o;
    endfunction

    function void note_request(pps_pkg::req_t r);
      sched_rsp_q.push_back(predict_rsp(r));
    endfunction

    function void cmp_field(string field, logic [TimeW-1:0] want, logic [TimeW-1:0] got);
      if (want !== got) begin
        $error("%s: expected %0d, got %0d", field, want, got);
        n_errors++;
      end
    endfunction

    function void check_result(pps_pkg::rsp_t got);
      pps_pkg::rsp_t want;
      if (sched_rsp_q.size() == 0) begin
        $error("result with no request waiting");
        n_errors++;
        return;
      end
      want = sched_rsp_q.pop_front();
      cmp_field("status", want.status, got.status);
      cmp_field("slot", want.slot, got.slot);
      cmp_field("finished", want.finished, got.finished);
      cmp_field("completion_time", want.completion_time, got.completion_time);
      cmp_field("turnaround", want.turnaround, got.turnaround);
      cmp_field("waiting", want.waiting, got.waiting);
      cmp_field("response", want.response, got.response);
      cmp_field("all_done", want.all_done, got.all_done);
      cmp_field("time_now", want.time_now, got.time_now);
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  pps_pkg::req_t req_i = '0;
  logic busy_o;
  logic valid_o;
  pps_pkg::rsp_t result_o;
  int unsigned quiet_cycles = 0;
  schedule_tracker sched;

  preemptive_priority_scheduler_unit dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .busy_o   (busy_o),
    .req_i    (req_i),
    .valid_o  (valid_o),
    .result_o (result_o)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni && valid_o) begin
      sched.check_result(result_o);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (start_i && !busy_o) || valid_o) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IdleLimit) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic pps_pkg::req_t make_load(logic [TimeW-1:0] arr, logic [TimeW-1:0] bur,
                                              logic [PrioInW-1:0] pri);
    pps_pkg::req_t r;
    r.kind = pps_pkg::KIND_LOAD;
    r.arrival_time = arr;
    r.burst_length = bur;
    r.task_priority = pri;
    return r;
  endfunction

  function automatic pps_pkg::req_t make_tick();
    pps_pkg::req_t r;
    r.kind = pps_pkg::KIND_TICK;
    r.arrival_time = TimeW'($urandom);
    r.burst_length = TimeW'($urandom);
    r.task_priority = PrioInW'($urandom);
    return r;
  endfunction

  // near arrivals keep tasks runnable before the counter tops out
  function automatic pps_pkg::req_t rand_load(bit saturated);
    logic [TimeW-1:0] arr;
    logic [TimeW-1:0] bur;
    logic [PrioInW-1:0] pri;
    if (saturated || $urandom_range(0, 7) == 0) begin
      arr = TimeW'($urandom_range(0, 65535));
    end else begin
      arr = TimeW'(sched.now + $urandom_range(0, 20));
    end
    if (!saturated && $urandom_range(0, 9) == 0) begin
      bur = TimeW'($urandom_range(0, 65535));
    end else begin
      bur = TimeW'($urandom_range(0, 20));
    end
    if ($urandom_range(0, 2) == 0) begin
      pri = PrioInW'($urandom_range(0, 3) * 85);
    end else begin
      pri = PrioInW'($urandom_range(0, 255));
    end
    return make_load(arr, bur, pri);
  endfunction

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_request(pps_pkg::req_t r, bit allow_gap);
    int unsigned gap;
    if (allow_gap && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 13);
      start_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    start_i <= 1'b1;
    req_i <= r;
    do @(posedge clk_i); while (busy_o);
    sched.note_request(r);
    @(negedge clk_i);
  endtask

  initial begin
    bit gaps;
    sched = new();
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // empty table, zero burst, future arrival, equal priority, late load, preemption
    send_request(make_tick(), 1'b0);
    send_request(make_load(16'd0, 16'd0, 8'd0), 1'b0);
    send_request(make_load(16'd5, 16'd3, 8'd255), 1'b0);
    send_request(make_load(16'd0, 16'd2, 8'd0), 1'b0);
    repeat (5) send_request(make_tick(), 1'b0);
    send_request(make_load(16'd0, 16'd65535, 8'd0), 1'b0);
    repeat (3) send_request(make_tick(), 1'b0);
    send_request(make_load(16'd65535, 16'd1, 8'd255), 1'b0);
    send_request(make_load(TimeW'(sched.now + 2), 16'd2, 8'd128), 1'b0);
    repeat (4) send_request(make_tick(), 1'b0);

    gaps = 1'b0;
    for (int i = 0; i < 600; i++) begin
      if (i % 40 == 0) begin
        gaps = $urandom_range(0, 1);
      end
      if (sched.task_count < WalkTaskCap && $urandom_range(0, 19) == 0) begin
        send_request(rand_load(1'b0), gaps);
      end else begin
        send_request(make_tick(), gaps);
      end
    end

    for (int i = 0; i < 550; i++) begin
      if (i % 40 == 0) begin
        gaps = $urandom_range(0, 1);
      end
      if (i >= 400) begin
        gaps = 1'b0;
      end
      if ($urandom_range(0, 3) == 0) begin
        send_request(rand_load(1'b1), gaps);
      end else begin
        send_request(make_tick(), gaps);
      end
    end
    start_i <= 1'b0;

    while (sched.sched_rsp_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    $display("covered %0d loads (%0d into a full table) and %0d ticks (%0d idle)",
             sched.n_load, sched.n_full, sched.n_tick, sched.n_idle);
    $display("%0d tasks completed, time counter ended at %0d",
             sched.n_finished, sched.now);
    if (sched.n_errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
